/* hdl/kpd_pkg.sv */
// Shared types, constants and the key character table of the keypad scanner.
package kpd_pkg;

  localparam int NUM_DIGITS_DEF = 16;
  localparam int NUM_COLS       = 4;
  localparam int ROW_W          = 2;
  localparam int SETTLE_W       = 16;
  localparam int CODE_W         = 5;
  localparam int CHAR_W         = 7;
  localparam int ENTRY_IDX_W    = 6;
  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int IN_DATA_W      = 8;
  localparam int OUT_DATA_W     = 32;
  localparam int CNT_W          = 3;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd10;
  localparam logic [SETTLE_W-1:0] SETTLE_MAX   = 16'hFFFF;

  localparam logic [CHAR_W-1:0] CHAR_DASH  = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_STAR  = 7'h2A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE   = 7'h31;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;

  localparam logic [3:0] KEY_IDX_ZERO = 4'd9;
  localparam logic [3:0] KEY_IDX_DASH = 4'd10;
  localparam logic [3:0] KEY_IDX_A    = 4'd11;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ENTRY_MODE   = 1'b0,
    CFG_SETTLE_TICKS = 1'b1
  } cfg_addr_t;

  typedef struct packed {
    logic [3:0]             row_drive;
    logic                   key_valid;
    logic [CODE_W-1:0]      key_code;
    logic [CHAR_W-1:0]      key_char;
    logic [CHAR_W-1:0]      mask_char;
    logic                   entry_written;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic                   scan_end;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]          count;
    res_t [NUM_COLS-1:0]       res;
  } batch_t;

  function automatic logic [CHAR_W-1:0] key_char_of(input logic [3:0] idx);
    logic [CHAR_W-1:0] ch;
    if (idx < KEY_IDX_ZERO) begin
      ch = CHAR_ONE + CHAR_W'(idx);
    end else if (idx == KEY_IDX_ZERO) begin
      ch = CHAR_ZERO;
    end else if (idx == KEY_IDX_DASH) begin
      ch = CHAR_DASH;
    end else begin
      ch = CHAR_LOW_A + CHAR_W'(idx - KEY_IDX_A);
    end
    return ch;
  endfunction

endpackage

/* hdl/kpd_core.sv */
// Scan state, configuration registers and the per-tick result batch.
module kpd_core #(
  parameter int NUM_DIGITS = kpd_pkg::NUM_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [kpd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [kpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            tick_acc,
  input  logic [kpd_pkg::NUM_COLS-1:0]    column_levels,
  input  logic                            clear_entry,
  output kpd_pkg::batch_t                 batch
);

  localparam int CUR_W = $clog2(NUM_DIGITS + 1);
  localparam logic [CUR_W-1:0] CUR_LIMIT = CUR_W'(NUM_DIGITS);

  logic                          entry_mode_r;
  logic [kpd_pkg::SETTLE_W-1:0]  settle_ticks_r;
  logic [kpd_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [kpd_pkg::SETTLE_W-1:0]  settle_r, settle_nxt;
  logic [CUR_W-1:0]              cursor_r, cursor_nxt;

  logic [kpd_pkg::SETTLE_W-1:0]  settle_inc;
  logic [kpd_pkg::SETTLE_W-1:0]  limit;
  logic                          sample;
  logic [3:0]                    drive;
  logic                          end_row;
  logic [CUR_W-1:0]              cur;
  logic [kpd_pkg::CNT_W-1:0]     n;
  logic [3:0]                    idx;
  kpd_pkg::res_t                 r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_mode_r   <= 1'b0;
      settle_ticks_r <= kpd_pkg::SETTLE_RESET;
    end else if (cfg_we) begin
      case (kpd_pkg::cfg_addr_t'(cfg_addr))
        kpd_pkg::CFG_ENTRY_MODE:   entry_mode_r   <= cfg_wdata[0];
        kpd_pkg::CFG_SETTLE_TICKS: settle_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      settle_r <= '0;
      cursor_r <= '0;
    end else if (tick_acc) begin
      row_r    <= row_nxt;
      settle_r <= settle_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  always_comb begin
    settle_inc = (settle_r < kpd_pkg::SETTLE_MAX) ? settle_r + 1'b1 : settle_r;
    limit      = (settle_ticks_r == '0) ? kpd_pkg::SETTLE_W'(1) : settle_ticks_r;
    sample     = (settle_inc >= limit);
    drive      = ~(4'b0001 << row_r);
    end_row    = sample && (row_r == 2'd3);
    cur        = clear_entry ? '0 : cursor_r;
    n          = '0;

    batch.count = kpd_pkg::CNT_W'(1);
    batch.res   = '0;
    for (int c = 0; c < kpd_pkg::NUM_COLS; c++) begin
      idx = {row_r, 2'(c)};
      r   = '0;
      r.row_drive = drive;
      r.key_valid = 1'b1;
      r.key_code  = kpd_pkg::CODE_W'(idx) + 1'b1;
      r.key_char  = kpd_pkg::key_char_of(idx);
      r.mask_char = (idx == kpd_pkg::KEY_IDX_DASH) ? kpd_pkg::CHAR_DASH : kpd_pkg::CHAR_STAR;
      r.scan_end  = end_row;
      if (sample && !column_levels[c]) begin
        if (entry_mode_r) begin
          if (cur < CUR_LIMIT) begin
            r.entry_written = 1'b1;
            r.entry_index   = kpd_pkg::ENTRY_IDX_W'(cur);
            cur             = cur + 1'b1;
          end
          if (idx == kpd_pkg::KEY_IDX_DASH) begin
            cur = '0;
          end
        end
        batch.res[n[1:0]] = r;
        n = n + 1'b1;
      end
    end

    if (n == '0) begin
      batch.res[0]           = '0;
      batch.res[0].row_drive = drive;
      batch.res[0].scan_end  = end_row;
    end else begin
      batch.count = n;
    end

    cursor_nxt = cur;
    if (sample) begin
      settle_nxt = '0;
      row_nxt    = row_r + 1'b1;
    end else begin
      settle_nxt = settle_inc;
      row_nxt    = row_r;
    end
  end

endmodule

/* hdl/kpd_outq.sv */
// Result register bank: holds one tick's results and hands them out one a cycle while take is high.
module kpd_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  kpd_pkg::batch_t  batch,
  input  logic             take,
  output logic             empty,
  output logic             one_left,
  output kpd_pkg::res_t    head
);

  kpd_pkg::res_t [kpd_pkg::NUM_COLS-1:0] ent_r, ent_nxt;
  logic [kpd_pkg::CNT_W-1:0]             cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load) begin
      ent_nxt = batch.res;
      cnt_nxt = batch.count;
    end else if (take) begin
      for (int i = 0; i < kpd_pkg::NUM_COLS - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign empty    = (cnt_r == '0);
  assign one_left = (cnt_r == kpd_pkg::CNT_W'(1));
  assign head     = ent_r[0];

endmodule

/* hdl/keypad_scan_digit_entry.sv */
// Top level of the 4x4 keypad scanner with digit entry.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+----------------------------------------------
//  in_     | in_tvalid/in_tready | tdata: column_levels, clear_entry
//  out_    | out_tvalid/tready   | tdata: row_drive .. scan_end; tuser: key_valid;
//          |                     | tlast: last result of the tick
//  cfg_    | cfg_we              | cfg_addr: 0 entry_mode, 1 settle_ticks
//
// A tick is resolved in the cycle it is accepted and its results appear in the cycle after.
// A tick with k pressed keys in the sampled row gives k results, otherwise one;
// these leave at one per cycle while out_tready is high.
// The next tick is taken in the cycle the previous tick's last result is taken.
// Output stalls hold the results and drop in_tready. Reset: rst_n, synchronous.
module keypad_scan_digit_entry #(
  parameter int NUM_DIGITS = kpd_pkg::NUM_DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [kpd_pkg::IN_DATA_W-1:0]    in_tdata,   // [3:0] column_levels, [4] clear_entry
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [kpd_pkg::OUT_DATA_W-1:0]   out_tdata,  // [3:0] row_drive, [8:4] key_code,
                                                       // [15:9] key_char, [22:16] mask_char,
                                                       // [23] entry_written,
                                                       // [29:24] entry_index, [30] scan_end
  output logic                             out_tuser,  // [0] key_valid
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [kpd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [kpd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  kpd_pkg::batch_t batch;
  kpd_pkg::res_t   head;
  logic            tick_acc;
  logic            take;
  logic            empty;
  logic            one_left;

  assign take      = out_tvalid && out_tready;
  assign in_tready = empty || (take && one_left);
  assign tick_acc  = in_tvalid && in_tready;

  kpd_core #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .tick_acc      (tick_acc),
    .column_levels (in_tdata[3:0]),
    .clear_entry   (in_tdata[4]),
    .batch         (batch)
  );

  kpd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (tick_acc),
    .batch    (batch),
    .take     (take),
    .empty    (empty),
    .one_left (one_left),
    .head     (head)
  );

  assign out_tvalid = !empty;
  assign out_tlast  = one_left;
  assign out_tuser  = head.key_valid;
  assign out_tdata  = {1'b0, head.scan_end, head.entry_index, head.entry_written,
                       head.mask_char, head.key_char, head.key_code, head.row_drive};

endmodule

/* verif/keypad_scan_digit_entry_tb.sv */
// Testbench for the keypad scanner: directed and random ticks, checked against a scan predictor.
`timescale 1ns / 1ps

module keypad_scan_digit_entry_tb;

  typedef struct packed {
    kpd_pkg::res_t res;
    logic          last;
  } key_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [kpd_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [kpd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [kpd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [kpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  bit calm = 1'b0;
  int fails = 0;

  // scan predictor state and register copies
  logic [1:0] scan_row = '0;
  int settle_seen = 0;
  int entry_cursor = 0;
  logic mode_entry = 1'b0;
  logic [kpd_pkg::SETTLE_W-1:0] settle_limit = kpd_pkg::SETTLE_RESET;

  key_result_t pending_keys[$];

  keypad_scan_digit_entry DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 18);
  end

  task automatic predict_tick(input logic [3:0] cols, input logic clr);
    key_result_t batch[$];
    key_result_t r;
    logic [3:0] drive;
    logic [3:0] idx;
    logic [kpd_pkg::CHAR_W-1:0] ch;
    int limit;
    drive = ~(4'b0001 << scan_row);
    limit = (settle_limit == 0) ? 1 : int'(settle_limit);
    if (clr) entry_cursor = 0;
    if (settle_seen < int'(kpd_pkg::SETTLE_MAX)) settle_seen++;
    if (settle_seen >= limit) begin
      for (int c = 0; c < kpd_pkg::NUM_COLS; c++) begin
        if (!cols[c]) begin
          idx = {scan_row, 2'(c)};
          if (idx < kpd_pkg::KEY_IDX_ZERO) begin
            ch = kpd_pkg::CHAR_ONE + kpd_pkg::CHAR_W'(idx);
          end else if (idx == kpd_pkg::KEY_IDX_ZERO) begin
            ch = kpd_pkg::CHAR_ZERO;
          end else if (idx == kpd_pkg::KEY_IDX_DASH) begin
            ch = kpd_pkg::CHAR_DASH;
          end else begin
            ch = kpd_pkg::CHAR_LOW_A + kpd_pkg::CHAR_W'(idx - kpd_pkg::KEY_IDX_A);
          end
          r = '0;
          r.res.row_drive = drive;
          r.res.key_valid = 1'b1;
          r.res.key_code = kpd_pkg::CODE_W'(idx) + 5'd1;
          r.res.key_char = ch;
          r.res.mask_char = (ch == kpd_pkg::CHAR_DASH) ? kpd_pkg::CHAR_DASH : kpd_pkg::CHAR_STAR;
          if (mode_entry) begin
            if (entry_cursor < kpd_pkg::NUM_DIGITS_DEF) begin
              r.res.entry_written = 1'b1;
              r.res.entry_index = kpd_pkg::ENTRY_IDX_W'(entry_cursor);
              entry_cursor++;
            end
            if (ch == kpd_pkg::CHAR_DASH) entry_cursor = 0;
          end
          r.res.scan_end = (scan_row == 2'd3);
          batch.push_back(r);
        end
      end
      if (batch.size() == 0) begin
        r = '0;
        r.res.row_drive = drive;
        r.res.scan_end = (scan_row == 2'd3);
        batch.push_back(r);
      end
      settle_seen = 0;
      scan_row = scan_row + 2'd1;
    end else begin
      r = '0;
      r.res.row_drive = drive;
      batch.push_back(r);
    end
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_keys.push_back(batch[i]);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : result_check
    key_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_keys.size() == 0) begin
        $error("result transaction with nothing expected: tdata %h", out_tdata);
        fails++;
      end else begin
        want = pending_keys.pop_front();
        compare_field("row_drive", want.res.row_drive, out_tdata[3:0]);
        compare_field("key_valid", want.res.key_valid, out_tuser);
        compare_field("key_code", want.res.key_code, out_tdata[8:4]);
        compare_field("key_char", want.res.key_char, out_tdata[15:9]);
        compare_field("mask_char", want.res.mask_char, out_tdata[22:16]);
        compare_field("entry_written", want.res.entry_written, out_tdata[23]);
        compare_field("entry_index", want.res.entry_index, out_tdata[29:24]);
        compare_field("scan_end", want.res.scan_end, out_tdata[30]);
        compare_field("last", want.last, out_tlast);
      end
    end
  end

  task automatic send_tick(input logic [3:0] cols, input logic clr);
    if (!calm && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, clr, cols};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_tick(cols, clr);
  endtask

  task automatic drain;
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_keys.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input kpd_pkg::cfg_addr_t addr,
                           input logic [kpd_pkg::CFG_DATA_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (addr == kpd_pkg::CFG_ENTRY_MODE) mode_entry = value[0];
    else settle_limit = value;
  endtask

  task automatic test_reset_values;
    for (int i = 0; i < 9; i++) send_tick(4'($urandom_range(15)), i == 4);
    send_tick(4'h0, 1'b0);
  endtask

  task automatic test_all_keys;
    write_reg(kpd_pkg::CFG_SETTLE_TICKS, 16'd1);
    for (int i = 0; i < 4; i++) send_tick(4'h0, i == 3);
    send_tick(4'hF, 1'b0);
  endtask

  task automatic test_settle_limits;
    write_reg(kpd_pkg::CFG_SETTLE_TICKS, 16'd0);
    send_tick(4'b1010, 1'b0);
    send_tick(4'b0101, 1'b0);
    write_reg(kpd_pkg::CFG_SETTLE_TICKS, kpd_pkg::SETTLE_MAX);
    for (int i = 0; i < 3; i++) send_tick(4'h0, 1'b0);
    // lower the limit below the ticks already counted
    write_reg(kpd_pkg::CFG_SETTLE_TICKS, 16'd2);
    send_tick(4'b0110, 1'b0);
  endtask

  task automatic test_entry_cursor;
    write_reg(kpd_pkg::CFG_ENTRY_MODE, 16'd1);
    write_reg(kpd_pkg::CFG_SETTLE_TICKS, 16'd1);
    send_tick(4'hF, 1'b1);
    // keep column 2 released so no dash key interrupts filling the entry
    for (int i = 0; i < 6; i++) send_tick(4'b0100, 1'b0);
    for (int i = 0; i < 4; i++) send_tick(4'h0, 1'b0);
    send_tick(4'b1110, 1'b1);
  endtask

  task automatic run_random(input int count, input bit dash_rare);
    logic [3:0] cols;
    for (int i = 0; i < count; i++) begin
      cols = 4'($urandom_range(15));
      if (dash_rare && $urandom_range(3) != 0) cols[2] = 1'b1;
      send_tick(cols, $urandom_range(99) < 6);
    end
  endtask

  task automatic test_random_traffic;
    write_reg(kpd_pkg::CFG_SETTLE_TICKS, 16'd1);
    run_random(35, 1'b1);
    write_reg(kpd_pkg::CFG_ENTRY_MODE, 16'd0);
    write_reg(kpd_pkg::CFG_SETTLE_TICKS, 16'd3);
    run_random(30, 1'b0);
    write_reg(kpd_pkg::CFG_ENTRY_MODE, 16'd1);
    write_reg(kpd_pkg::CFG_SETTLE_TICKS, 16'd2);
    calm = 1'b1;
    run_random(35, 1'b1);
    calm = 1'b0;
    write_reg(kpd_pkg::CFG_SETTLE_TICKS, 16'd1);
    run_random(35, 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_all_keys();
    test_settle_limits();
    test_entry_cursor();
    test_random_traffic();
    drain();
    if (pending_keys.size() != 0) begin
      $error("%0d expected results never arrived", pending_keys.size());
      fails++;
    end
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
